### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Screen geometry, field widths, action codes and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  // field widths
  localparam int ACT_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int POS_W   = 11;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  // character and color constants
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd15;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } tcw_act_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_DECODE,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_DONE
  } tcw_state_t;

endpackage

### design/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: word channels of the text console writer
// Request channel (action and position) and result channel (cursor and cell).
// ----------------------------------------------------------------------------
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;

  modport source (output valid, action, char_code, row, col, input ready);
  modport sink   (input valid, action, char_code, row, col, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   cursor_position;
  logic [CHAR_W-1:0]  cell_char;
  logic [COLOR_W-1:0] cell_color;

  modport source (output valid, cursor_position, cell_char, cell_color, input ready);
  modport sink   (input valid, cursor_position, cell_char, cell_color, output ready);
endinterface

### design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top: text-mode character screen engine
// Keeps a grid of character/color cells and a cursor; puts characters,
// moves the cursor, clears the screen and reads back cells.
//
//   channel   direction  handshake       word
//   in_ch     sink       valid/ready     action, char_code, row, col
//   out_ch    source     valid/ready     cursor_position, cell_char, cell_color
//   cfg_*     sink       cfg_we          text_color (cfg_wdata)
//
// Put, set cursor and read cell go from ST_DECODE to ST_DONE; the result is
// loaded in the same cycle the next word is taken. Clear walks all ROWS*COLS
// cells through the single RAM write port; a put that scrolls copies
// (ROWS-1)*COLS cells up one row via ST_SCR_RD then ST_SCR_WR, then blanks
// COLS cells. After reset a clearing pass over all ROWS*COLS cells runs with
// in_ch.ready low. A stalled result holds the sequencer in its final state until taken.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  tcw_in_if.sink             in_ch,
  tcw_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [COLOR_W-1:0] cfg_wdata
);

  tcw_state_t state_r, state_nxt;

  logic                boot_r;
  logic [ADDR_W-1:0]   sweep_r;
  logic [COLOR_W-1:0]  fill_color_r;
  logic [COLOR_W-1:0]  text_color_r;
  logic [ROW_W-1:0]    cur_row_r;
  logic [COL_W-1:0]    cur_col_r;
  logic [ADDR_W-1:0]   cur_lin_r;

  // captured request word
  tcw_act_t            act_r;
  logic [CHAR_W-1:0]   chr_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;

  // result register
  logic                out_valid_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [CHAR_W-1:0]   out_chr_r;
  logic [COLOR_W-1:0]  out_clr_r;

  // RAM port signals
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  logic                accept, out_free, out_load;
  logic                fill_last, copy_last;

  // ---- cursor arithmetic ---------------------------------------------------
  logic                is_newline, wrap, scroll;
  logic [ROW_W-1:0]    put_row_nxt, row_cl;
  logic [COL_W-1:0]    put_col_nxt, col_cl;
  logic [ROW_W-1:0]    mul_row;
  logic [COL_W-1:0]    mul_col;
  logic [ADDR_W-1:0]   mul_sum;
  logic [ADDR_W+POS_W-1:0] lin_ext;

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign fill_last = (sweep_r == ADDR_W'(CELLS - 1));
  assign copy_last = (sweep_r == ADDR_W'(CELLS - COLS - 1));

  // advance cursor for a put
  assign is_newline = (chr_r == NEWLINE_CHAR);
  assign wrap       = is_newline || (cur_col_r == COL_W'(COLS - 1));
  assign scroll     = (act_r == ACT_PUT) && wrap && (cur_row_r == ROW_W'(ROWS - 1));

  always_comb begin
    put_row_nxt = cur_row_r;
    put_col_nxt = cur_col_r + COL_W'(1);
    if (wrap) begin
      put_col_nxt = '0;
      put_row_nxt = (cur_row_r == ROW_W'(ROWS - 1)) ? cur_row_r : cur_row_r + ROW_W'(1);
    end
  end

  // clamp requested position to the screen
  assign row_cl = ({1'b0, row_r} >= (ROW_W + 1)'(ROWS)) ? ROW_W'(ROWS - 1) : row_r;
  assign col_cl = ({1'b0, col_r} >= (COL_W + 1)'(COLS)) ? COL_W'(COLS - 1) : col_r;

  // shared row * COLS + col unit
  assign mul_row = (act_r == ACT_PUT) ? put_row_nxt : row_cl;
  assign mul_col = (act_r == ACT_PUT) ? put_col_nxt : col_cl;
  assign mul_sum = ADDR_W'(mul_row) * ADDR_W'(COLS) + ADDR_W'(mul_col);

  assign lin_ext = {POS_W'(0), cur_lin_r};

  // ---- next state ----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (fill_last) state_nxt = boot_r ? ST_IDLE : ST_DONE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (act_r == ACT_CLEAR) state_nxt = ST_FILL;
        else if (scroll)        state_nxt = ST_SCR_RD;
        else                    state_nxt = ST_DONE;
      end
      ST_SCR_RD: state_nxt = ST_SCR_WR;
      ST_SCR_WR: begin
        state_nxt = copy_last ? ST_FILL : ST_SCR_RD;
      end
      ST_DONE: begin
        if (out_free) state_nxt = accept ? ST_DECODE : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- sequencer outputs ---------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = sweep_r;
    ram_wdata   = {BLANK_CHAR, fill_color_r};
    ram_re      = 1'b0;
    ram_raddr   = mul_sum;
    unique case (state_r)
      ST_FILL: ram_we = 1'b1;
      ST_IDLE: in_ch.ready = 1'b1;
      ST_DECODE: begin
        if (act_r == ACT_PUT && !is_newline) begin
          ram_we    = 1'b1;
          ram_waddr = cur_lin_r;
          ram_wdata = {chr_r, text_color_r};
        end
        if (act_r == ACT_READ) ram_re = 1'b1;
      end
      ST_SCR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sweep_r + ADDR_W'(COLS);
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_DONE: begin
        out_load    = out_free;
        in_ch.ready = out_free;
      end
      default: ;
    endcase
  end

  // ---- control registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      boot_r       <= 1'b1;
      sweep_r      <= '0;
      fill_color_r <= RESET_COLOR;
      text_color_r <= RESET_COLOR;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      cur_lin_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // text color register, loaded on cfg_we
      if (cfg_we) text_color_r <= cfg_wdata;

      unique case (state_r)
        ST_FILL: begin
          sweep_r <= sweep_r + ADDR_W'(1);
          if (fill_last) boot_r <= 1'b0;
        end
        ST_DECODE: begin
          unique case (act_r)
            ACT_PUT, ACT_SET: begin
              cur_row_r <= mul_row;
              cur_col_r <= mul_col;
              cur_lin_r <= mul_sum;
              sweep_r   <= '0;
            end
            ACT_CLEAR: begin
              cur_row_r    <= '0;
              cur_col_r    <= '0;
              cur_lin_r    <= '0;
              sweep_r      <= '0;
              fill_color_r <= text_color_r;
            end
            ACT_READ: ;
            default: ;
          endcase
        end
        ST_SCR_WR: begin
          sweep_r <= sweep_r + ADDR_W'(1);
          if (copy_last) fill_color_r <= text_color_r;
        end
        default: ;
      endcase

      // drop result once taken, load new one
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // ---- payload registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= tcw_act_t'(in_ch.action);
      chr_r <= in_ch.char_code;
      row_r <= in_ch.row;
      col_r <= in_ch.col;
    end
    if (out_load) begin
      out_pos_r <= lin_ext[POS_W-1:0];
      out_chr_r <= (act_r == ACT_READ) ? ram_rdata[CELL_W-1:COLOR_W] : '0;
      out_clr_r <= (act_r == ACT_READ) ? ram_rdata[COLOR_W-1:0] : '0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.cell_char       = out_chr_r;
  assign out_ch.cell_color      = out_clr_r;

  // ---- screen store --------------------------------------------------------
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### design/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches the channel ports over time and reports violations.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] cursor_position
);

  // hold result word until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // cursor stays on the screen
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CELLS > (1 << POS_W)) || (cursor_position <= POS_W'(CELLS - 1)))
    else $error("cursor position beyond last cell");

  // block clearing pass right after reset
  a_boot_busy: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("request taken during post-reset clearing pass");

  // one request at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one is in progress");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .cursor_position (out_ch.cursor_position)
);
